// ===== hdl/bcc_pkg.sv =====
// Package for the button click classifier: event and phase codes, the
// configuration and status structures, and register reset values.
// No dependencies; bcc_core, the top level and the testbench import it.
`timescale 1ns / 1ps

package bcc_pkg;

    // Event codes reported once per sampling tick.
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } click_event_t;

    // Phases of the press (debounce) machine.
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASE  = 2'd3
    } press_phase_t;

    // Register indexes as seen on the configuration port.
    typedef enum logic {
        REG_LONG_PRESS = 1'b0,
        REG_WINDOW     = 1'b1
    } reg_index_t;

    localparam logic [15:0] LONG_PRESS_RESET = 16'd50;
    localparam logic [7:0]  WINDOW_RESET     = 8'd15;

    // Configuration handed from the register file to the classifier.
    typedef struct packed {
        logic [15:0] long_press_ticks;
        logic [7:0]  double_click_window;
    } bcc_cfg_t;

    // Internal state exposed for checking.
    typedef struct packed {
        press_phase_t press_phase;
        logic         click_wait;
    } bcc_status_t;

endpackage

// ===== hdl/bcc_stream_if.sv =====
// Valid/ready channel interfaces for the button click classifier:
// the sampled pin level going in and the event code coming out.
// Depends on nothing.
`timescale 1ns / 1ps

interface bcc_level_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface bcc_click_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

// ===== hdl/bcc_core.sv =====
// Classifier core: press debounce machine and double-click pairing machine.
// State advances by one sampling tick whenever step is high.
// Depends on bcc_pkg.
`timescale 1ns / 1ps

module bcc_core
    import bcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic        pressed,
    input  bcc_cfg_t    cfg,
    output logic [1:0]  event_code,
    output bcc_status_t status
);

    press_phase_t phase_reg, phase_next;
    logic [15:0]  hold_count_reg, hold_count_next;
    logic         click_wait_reg, click_wait_next;
    logic [7:0]   window_count_reg, window_count_next;
    click_event_t press_ev;
    click_event_t click_ev;
    logic [15:0]  hold_inc;
    logic [7:0]   window_inc;

    assign hold_inc   = hold_count_reg + 16'd1;
    assign window_inc = window_count_reg + 8'd1;

    // Press machine: two-tick debounce, short press on release, long press
    // once the hold count reaches the threshold.
    always_comb
    begin
        phase_next      = phase_reg;
        hold_count_next = hold_count_reg;
        press_ev        = EV_NONE;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (pressed)
                begin
                    phase_next      = PH_DEBOUNCE;
                    hold_count_next = 16'd0;
                end
            end
            PH_DEBOUNCE:
            begin
                if (pressed)
                begin
                    phase_next      = PH_HELD;
                    hold_count_next = 16'd0;
                end
                else
                begin
                    phase_next = PH_IDLE;
                end
            end
            PH_HELD:
            begin
                if (!pressed)
                begin
                    press_ev        = EV_SHORT;
                    phase_next      = PH_IDLE;
                    hold_count_next = 16'd0;
                end
                else if (hold_count_reg >= cfg.long_press_ticks)
                begin
                    press_ev        = EV_LONG;
                    phase_next      = PH_RELEASE;
                    hold_count_next = 16'd0;
                end
                else
                begin
                    hold_count_next = hold_inc;
                end
            end
            PH_RELEASE:
            begin
                if (!pressed)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Pairing machine: a short press is held for the window; a second one
    // gives a double click, a timeout releases the single short press. A long
    // press during the window is dropped.
    always_comb
    begin
        click_wait_next   = click_wait_reg;
        window_count_next = window_count_reg;
        click_ev          = EV_NONE;
        if (!click_wait_reg)
        begin
            if (press_ev == EV_SHORT)
            begin
                window_count_next = 8'd0;
                click_wait_next   = 1'b1;
            end
            else
            begin
                click_ev = press_ev;
            end
        end
        else
        begin
            if (press_ev == EV_SHORT)
            begin
                click_ev        = EV_DOUBLE;
                click_wait_next = 1'b0;
            end
            else
            begin
                window_count_next = window_inc;
                if (window_inc >= cfg.double_click_window)
                begin
                    click_ev        = EV_SHORT;
                    click_wait_next = 1'b0;
                end
            end
        end
    end

    // State registers, advanced one tick per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            hold_count_reg   <= 16'd0;
            click_wait_reg   <= 1'b0;
            window_count_reg <= 8'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            hold_count_reg   <= hold_count_next;
            click_wait_reg   <= click_wait_next;
            window_count_reg <= window_count_next;
        end
    end

    assign event_code          = click_ev;
    assign status.press_phase  = phase_reg;
    assign status.click_wait   = click_wait_reg;

endmodule

// ===== hdl/button_click_classifier_unit.sv =====
// Top level of the button click classifier: input register, classifier
// core, result register and APB-style configuration registers.
// Depends on bcc_pkg, bcc_stream_if.sv and bcc_core.
`timescale 1ns / 1ps

// The block takes one sampled pin level per request (0 means pressed) and
// returns exactly one event code for each: 0 none, 1 short press, 2 double
// click, 3 long press. It accepts a request in every clock cycle while the
// level side is not held off. A request passes through an input register,
// the classifier logic and a result register, which presents its event on
// the click side until it is taken. Both stages hold their data while the
// output is stalled, and the level side is held off only when both are full
// and the click side is not ready.
// Register 0 (byte address 0) is long_press_ticks, reset 50; register 1
// (byte address 4) is double_click_window, reset 15. Write them only while
// no request is in flight.
module button_click_classifier_unit
    import bcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    bcc_level_if.sink         level,
    bcc_click_if.source       click,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    bcc_cfg_t    cfg_reg;
    logic        s1_valid_reg;
    logic        s1_level_reg;
    logic        out_valid_reg;
    logic [1:0]  out_code_reg;
    logic        advance;
    logic        cfg_write;
    reg_index_t  cfg_index;
    logic [1:0]  core_event;
    bcc_status_t core_status;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ticks    <= LONG_PRESS_RESET;
            cfg_reg.double_click_window <= WINDOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS: cfg_reg.long_press_ticks    <= pwdata[15:0];
                REG_WINDOW:     cfg_reg.double_click_window <= pwdata[7:0];
                default:        ;
            endcase
        end
    end

    // Read back.
    always_comb
    begin
        unique case (cfg_index)
            REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ticks};
            REG_WINDOW:     prdata = {24'd0, cfg_reg.double_click_window};
            default:        prdata = 32'd0;
        endcase
    end

    // Pipeline flow: stage one advances into the result register when that
    // register is empty or being drained.
    assign advance     = s1_valid_reg && (!out_valid_reg || click.ready);
    assign level.ready = !s1_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (level.valid && level.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (level.valid && level.ready)
        begin
            s1_level_reg <= level.pin_level;
        end
    end

    // Classifier state machines.
    bcc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .pressed    (!s1_level_reg),
        .cfg        (cfg_reg),
        .event_code (core_event),
        .status     (core_status)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (click.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= core_event;
        end
    end

    assign click.valid      = out_valid_reg;
    assign click.event_code = out_code_reg;

    // A press must pass the debounce phase before it is counted as held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_status.press_phase == PH_IDLE)
        |=> core_status.press_phase != PH_HELD)
        else $error("press machine skipped debounce");

    // A double click can only come from a short press already being held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && core_event == EV_DOUBLE) |-> core_status.click_wait)
        else $error("double click without a held short press");

    // A full input stage that cannot advance must hold off new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |-> !level.ready)
        else $error("input stage overwritten while stalled");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for button_click_classifier_unit: stimulus tasks,
// an event scoreboard class and the APB register tasks.
// Depends on bcc_pkg, bcc_stream_if.sv and the block's RTL.
`timescale 1ns / 1ps

module testbench
    import bcc_pkg::*;
;

    localparam int HOLD_OFF_CYCLES = 300;

    // Tracks the classifier state for every accepted pin sample and keeps
    // the event codes that the block still owes.
    class click_scoreboard;
        logic [15:0]  long_press_ticks;
        logic [7:0]   click_window;
        press_phase_t phase;
        logic [15:0]  hold_count;
        bit           waiting_second;
        logic [7:0]   window_count;
        click_event_t owed_events[$];
        int           events_checked;
        int           seen[4];

        function new();
            long_press_ticks = LONG_PRESS_RESET;
            click_window     = WINDOW_RESET;
            phase            = PH_IDLE;
            hold_count       = '0;
            waiting_second   = 1'b0;
            window_count     = '0;
            events_checked   = 0;
            foreach (seen[i])
                seen[i] = 0;
        endfunction

        function void set_register(reg_index_t idx, logic [31:0] value);
            if (idx == REG_LONG_PRESS)
                long_press_ticks = value[15:0];
            else
                click_window = value[7:0];
        endfunction

        // Advances both machines by one accepted sample.
        function void note_level(logic pin_level);
            click_event_t press_ev;
            click_event_t ev;
            bit           pressed;
            pressed  = (pin_level == 1'b0);
            press_ev = EV_NONE;
            ev       = EV_NONE;

            // Press machine: two-sample debounce, then short or long press.
            case (phase)
                PH_IDLE:
                begin
                    if (pressed)
                    begin
                        phase      = PH_DEBOUNCE;
                        hold_count = '0;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (pressed)
                    begin
                        hold_count = '0;
                        phase      = PH_HELD;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_HELD:
                begin
                    if (!pressed)
                    begin
                        press_ev   = EV_SHORT;
                        phase      = PH_IDLE;
                        hold_count = '0;
                    end
                    else if (hold_count >= long_press_ticks)
                    begin
                        hold_count = '0;
                        press_ev   = EV_LONG;
                        phase      = PH_RELEASE;
                    end
                    else
                        hold_count = hold_count + 16'd1;
                end
                default:
                begin
                    if (!pressed)
                        phase = PH_IDLE;
                end
            endcase

            // Click pairing: a short press waits for a partner or a timeout,
            // and a long press during the wait is swallowed.
            if (!waiting_second)
            begin
                if (press_ev == EV_SHORT)
                begin
                    window_count   = '0;
                    waiting_second = 1'b1;
                end
                else
                    ev = press_ev;
            end
            else if (press_ev == EV_SHORT)
            begin
                ev             = EV_DOUBLE;
                waiting_second = 1'b0;
            end
            else
            begin
                window_count = window_count + 8'd1;
                if (window_count >= click_window)
                begin
                    ev             = EV_SHORT;
                    waiting_second = 1'b0;
                end
            end
            owed_events.push_back(ev);
        endfunction

        function bit check_event(input logic [1:0] got, output string why);
            click_event_t want;
            why = "";
            if (owed_events.size() == 0)
            begin
                why = $sformatf("event code %0d arrived with nothing owed", got);
                return 1'b0;
            end
            want = owed_events.pop_front();
            events_checked++;
            if (got !== want)
            begin
                why = $sformatf("event %0d: code %0d, wanted %0d (%s)",
                                events_checked, got, want, want.name());
                return 1'b0;
            end
            seen[want]++;
            return 1'b1;
        endfunction

        function int waiting();
            return owed_events.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bcc_level_if level_ch();
    bcc_click_if click_ch();

    click_scoreboard sb;
    string           mismatch_text;
    int              error_count    = 0;
    int              levels_sent    = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              hold_req       = 0;
    int              hold_done      = 0;
    int              cur_long;
    int              cur_window;
    int              settings_used  = 0;

    button_click_classifier_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .level   (level_ch),
        .click   (click_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    task report_mismatch(input string msg);
        $display("testbench: MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Observe both channels at each edge; requests are noted before results.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (level_ch.valid && level_ch.ready)
                sb.note_level(level_ch.pin_level);
            if (click_ch.valid && click_ch.ready)
            begin
                if (!sb.check_event(click_ch.event_code, mismatch_text))
                    report_mismatch(mismatch_text);
            end
        end
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        click_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                click_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
                hold_done++;
            end
            else
                click_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offers one pin sample and returns at the edge where it is taken.
    task send_level(input logic lvl);
        while ($urandom_range(99) < send_idle_pct)
        begin
            level_ch.valid <= 1'b0;
            @(posedge clk);
        end
        level_ch.valid     <= 1'b1;
        level_ch.pin_level <= lvl;
        do
        begin
            @(posedge clk);
        end
        while (!level_ch.ready);
        levels_sent++;
    endtask

    task send_run(input logic lvl, input int count);
        repeat (count) send_level(lvl);
    endtask

    task send_pattern(input string levels);
        for (int i = 0; i < levels.len(); i++)
            send_level(levels[i] == "1");
    endtask

    // Stops offering and waits until every owed event has been returned.
    task wait_drained();
        level_ch.valid <= 1'b0;
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_reg(input reg_index_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
    endtask

    // Read data is sampled mid-way through the access cycle.
    task read_check(input reg_index_t idx, input logic [31:0] mask,
                    input logic [31:0] want);
        logic [31:0] got;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata & mask;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== (want & mask))
            report_mismatch($sformatf("register %s reads %0d, wanted %0d",
                                      idx.name(), got, want & mask));
    endtask

    task set_timing(input int long_ticks, input int window);
        cur_long   = long_ticks;
        cur_window = window;
        write_reg(REG_LONG_PRESS, long_ticks);
        write_reg(REG_WINDOW, window);
        read_check(REG_LONG_PRESS, 32'h0000_FFFF, long_ticks);
        read_check(REG_WINDOW, 32'h0000_00FF, window);
        settings_used++;
    endtask

    // Mostly well-formed presses and gaps sized to the current timing,
    // with some short runs of random samples mixed in.
    task send_gestures(input int count);
        int start;
        int press_cap;
        int gap_cap;
        int pick;
        start     = levels_sent;
        press_cap = (cur_long > 60 ? 60 : cur_long) + 3;
        gap_cap   = (cur_window > 40 ? 40 : cur_window) + 4;
        while (levels_sent - start < count)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
            begin
                if ($urandom_range(0, 4) < 2)
                    send_run(1'b0, $urandom_range(2, 3));
                else
                    send_run(1'b0, $urandom_range(1, press_cap));
                if ($urandom_range(0, 1) == 0)
                    send_run(1'b1, $urandom_range(1, cur_window > 1 ? cur_window : 1));
                else
                    send_run(1'b1, $urandom_range(1, gap_cap));
            end
            else
                repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n              <= 1'b0;
        level_ch.valid     <= 1'b0;
        level_ch.pin_level <= 1'b1;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers come out of reset with their documented values.
        read_check(REG_LONG_PRESS, 32'h0000_FFFF, 32'(LONG_PRESS_RESET));
        read_check(REG_WINDOW, 32'h0000_00FF, 32'(WINDOW_RESET));

        // Directed gestures with an immediate long press and a short window.
        set_timing(0, 3);
        send_pattern("01");            // one-sample bounce is filtered out
        send_pattern("001111");        // short press reported on timeout
        send_pattern("001001");        // double click
        send_pattern("0010001");       // long press inside the window is dropped
        send_pattern("0001");          // long press outside the window passes
        wait_drained();

        // A zero window behaves as a window of one.
        set_timing(5, 0);
        send_pattern("0011");
        wait_drained();

        // Lowering the limits part-way through a count fires on the next sample.
        set_timing(1000, 200);
        send_run(1'b0, 20);
        wait_drained();
        set_timing(5, 200);
        send_pattern("01");
        send_pattern("001");
        send_run(1'b1, 10);
        wait_drained();
        set_timing(5, 4);
        send_pattern("1");
        wait_drained();

        // Largest limits: a hold well short of the long press, a double
        // click, then a single press that waits out the full window.
        set_timing(65535, 255);
        send_run(1'b0, 40);
        send_pattern("1001");
        send_pattern("001");
        send_run(1'b1, 256);
        wait_drained();

        // Random phases, cycling through the idling patterns.
        for (int p = 0; p < 8; p++)
        begin
            send_idle_pct  = (p % 4 == 1) ? 59 : (p % 4 == 3) ? 17 : 0;
            recv_stall_pct = (p % 4 == 2) ? 59 : (p % 4 == 3) ? 17 : 0;
            if (p == 7)
                set_timing(LONG_PRESS_RESET, WINDOW_RESET);
            else
                set_timing(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 24),
                           ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                       : $urandom_range(0, 12));
            // Hold the result side off while requests keep coming.
            if (p == 4)
                hold_req++;
            send_gestures(250);
            wait_drained();
        end

        $display("testbench: %0d pin samples over %0d timing settings, %0d events compared",
                 levels_sent, settings_used, sb.events_checked);
        $display("testbench: short %0d, double %0d, long %0d, none %0d",
                 sb.seen[EV_SHORT], sb.seen[EV_DOUBLE], sb.seen[EV_LONG],
                 sb.seen[EV_NONE]);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("testbench: timed out with %0d events still owed", sb.waiting());
        $display("testbench: done, errors");
        $finish;
    end

endmodule
